### rtl/core/tlpd_pkg.sv
`default_nettype none

package tlpd_pkg;

    // Coordinate and tick counter widths
    localparam int COORD_BITS = 12;
    localparam int TICK_BITS  = 16;

    // Configuration port geometry
    localparam int CFG_NUM_REGS = 6;
    localparam int CFG_IDX_W    = $clog2(CFG_NUM_REGS);
    localparam int CFG_DATA_W   = (TICK_BITS > COORD_BITS) ? TICK_BITS : COORD_BITS;

    // Stream widths: coordinates in tdata, event kind in tuser
    localparam int OP_W         = 2;
    localparam int IN_TDATA_W   = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_AREA_LEFT      = cfg_idx_t'(0);
    localparam cfg_idx_t REG_AREA_TOP       = cfg_idx_t'(1);
    localparam cfg_idx_t REG_AREA_WIDTH     = cfg_idx_t'(2);
    localparam cfg_idx_t REG_AREA_HEIGHT    = cfg_idx_t'(3);
    localparam cfg_idx_t REG_MOVE_TOLERANCE = cfg_idx_t'(4);
    localparam cfg_idx_t REG_HOLD_TICKS     = cfg_idx_t'(5);

    localparam logic [COORD_BITS-1:0] MOVE_TOLERANCE_RST = COORD_BITS'(20);
    localparam logic [TICK_BITS-1:0]  HOLD_TICKS_RST     = TICK_BITS'(1000);

    typedef enum logic [OP_W-1:0] {
        OP_PRESS   = 2'd0,
        OP_MOVE    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] area_left;
        logic [COORD_BITS-1:0] area_top;
        logic [COORD_BITS-1:0] area_width;
        logic [COORD_BITS-1:0] area_height;
        logic [COORD_BITS-1:0] move_tolerance;
        logic [TICK_BITS-1:0]  hold_ticks;
    } cfg_t;

    typedef struct packed {
        op_t                   op;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } event_t;

    typedef struct packed {
        logic long_press;
        logic armed;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/tlpd_cfg_regs.sv
`default_nettype none

module tlpd_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire tlpd_pkg::cfg_idx_t               cfg_wr_index,
    input  wire logic [tlpd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output tlpd_pkg::cfg_t                        cfg
);
    import tlpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [COORD_BITS-1:0] wr_coord;

    assign wr_coord = cfg_wr_data[COORD_BITS-1:0];

    // Writes past the register list fall into the default arm and are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_AREA_LEFT:      cfg_next.area_left      = wr_coord;
                REG_AREA_TOP:       cfg_next.area_top       = wr_coord;
                REG_AREA_WIDTH:     cfg_next.area_width     = wr_coord;
                REG_AREA_HEIGHT:    cfg_next.area_height    = wr_coord;
                REG_MOVE_TOLERANCE: cfg_next.move_tolerance = wr_coord;
                REG_HOLD_TICKS:     cfg_next.hold_ticks     = cfg_wr_data[TICK_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.area_left      <= '0;
            cfg_reg.area_top       <= '0;
            cfg_reg.area_width     <= '0;
            cfg_reg.area_height    <= '0;
            cfg_reg.move_tolerance <= MOVE_TOLERANCE_RST;
            cfg_reg.hold_ticks     <= HOLD_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/core/tlpd_step.sv
`default_nettype none

module tlpd_step (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step_en,
    input  wire tlpd_pkg::event_t evt,
    input  wire tlpd_pkg::cfg_t   cfg,
    output tlpd_pkg::result_t     res
);
    import tlpd_pkg::*;

    logic                  holding_reg;
    logic                  holding_next;
    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_x_next;
    logic [COORD_BITS-1:0] start_y_reg;
    logic [COORD_BITS-1:0] start_y_next;
    logic [TICK_BITS-1:0]  elapsed_reg;
    logic [TICK_BITS-1:0]  elapsed_next;
    logic [TICK_BITS-1:0]  elapsed_inc;
    logic                  pulse;

    // Rectangle edges carry one extra bit so they never wrap
    logic [COORD_BITS:0]   right_edge;
    logic [COORD_BITS:0]   bottom_edge;
    logic                  in_area;
    logic [COORD_BITS-1:0] drift_x;
    logic [COORD_BITS-1:0] drift_y;
    logic                  drift_out;

    assign right_edge  = {1'b0, cfg.area_left} + {1'b0, cfg.area_width};
    assign bottom_edge = {1'b0, cfg.area_top} + {1'b0, cfg.area_height};
    assign in_area = (evt.pos_x >= cfg.area_left) && ({1'b0, evt.pos_x} <= right_edge) &&
                     (evt.pos_y >= cfg.area_top)  && ({1'b0, evt.pos_y} <= bottom_edge);

    assign drift_x = (evt.pos_x >= start_x_reg) ? (evt.pos_x - start_x_reg)
                                                : (start_x_reg - evt.pos_x);
    assign drift_y = (evt.pos_y >= start_y_reg) ? (evt.pos_y - start_y_reg)
                                                : (start_y_reg - evt.pos_y);
    assign drift_out = (drift_x > cfg.move_tolerance) || (drift_y > cfg.move_tolerance);

    // Saturate at the counter's top value
    assign elapsed_inc = (elapsed_reg == {TICK_BITS{1'b1}}) ? elapsed_reg
                                                           : elapsed_reg + 1'b1;

    always_comb begin
        holding_next = holding_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        elapsed_next = elapsed_reg;
        pulse        = 1'b0;
        case (evt.op)
            OP_PRESS: begin
                if (in_area) begin
                    holding_next = 1'b1;
                    start_x_next = evt.pos_x;
                    start_y_next = evt.pos_y;
                    elapsed_next = '0;
                end
            end
            OP_MOVE: begin
                if (holding_reg && drift_out) begin
                    holding_next = 1'b0;
                end
            end
            OP_RELEASE: begin
                holding_next = 1'b0;
            end
            OP_TICK: begin
                if (holding_reg) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= cfg.hold_ticks) begin
                        pulse        = 1'b1;
                        holding_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holding_reg <= 1'b0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            elapsed_reg <= '0;
        end else if (step_en) begin
            holding_reg <= holding_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign res.long_press = pulse;
    assign res.armed      = holding_next;

    // A long-press pulse always disarms
    a_pulse_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && pulse |=> !holding_reg)
        else $error("long press left detector armed");

    // A press inside the rectangle arms with a cleared counter
    a_press_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && evt.op == OP_PRESS && in_area |=> holding_reg && elapsed_reg == '0)
        else $error("press inside rectangle did not arm");

    // Only a press can arm
    a_only_press_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        !holding_reg && !(step_en && evt.op == OP_PRESS) |=> !holding_reg)
        else $error("armed without a press");

    // A tick while armed advances the counter by one below saturation
    a_tick_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && evt.op == OP_TICK && holding_reg && elapsed_reg != {TICK_BITS{1'b1}}
        |=> elapsed_reg == $past(elapsed_reg) + 1'b1)
        else $error("hold counter did not advance");

endmodule

`default_nettype wire

### rtl/core/touch_long_press_detector_core.sv
`default_nettype none

// A taken request waits in the request register, which feeds the event logic;
// its answer is then held in the result register and shown on the m_ side.
// One request per cycle while m_tready stays high, so both sides stream back to back.
// Reset (aresetn low, synchronous): both stages empty, detector disarmed,
// hold counter and start point cleared, registers back to their defaults.

module touch_long_press_detector_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input request stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [tlpd_pkg::IN_TDATA_W-1:0]    s_tdata,  // pos_x, pos_y
    input  wire logic [tlpd_pkg::OP_W-1:0]          s_tuser,  // op
    // Result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [tlpd_pkg::OUT_TDATA_W-1:0]        m_tdata,  // long_press, armed, zero pad
    // Configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire tlpd_pkg::cfg_idx_t                 cfg_wr_index,
    input  wire logic [tlpd_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import tlpd_pkg::*;

    cfg_t    cfg;
    event_t  in_evt;
    result_t step_res;

    // Request stage
    logic    in_valid_reg;
    logic    in_valid_next;
    event_t  in_evt_reg;

    // Result stage
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    logic    s_fire;
    logic    advance;

    tlpd_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Unpack the request: coordinates from tdata, event kind from tuser
    assign in_evt.op    = op_t'(s_tuser);
    assign in_evt.pos_x = s_tdata[COORD_BITS-1:0];
    assign in_evt.pos_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

    // Advance the held request into the result stage whenever that stage
    // is empty or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Event logic updates detector state only when its request moves on
    tlpd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .evt     (in_evt_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on handshake, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_evt_reg <= in_evt;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_res_reg.armed, out_res_reg.long_press});

endmodule

`default_nettype wire
